FILE: hw/rtl/markup_run_tokenizer_assert.svh
// Assertion macros for the markup run tokenizer.
// Taken in by the top level; needs nothing else.
`ifndef MARKUP_RUN_TOKENIZER_ASSERT_SVH
`define MARKUP_RUN_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mrt_pkg.sv
// Shared types and constants of the markup run tokenizer.
// Used by every module of the block; depends on nothing.
package mrt_pkg;

   // Saturation limit of line offsets and run lengths.
   localparam int LineLengthMax = 65535;
   localparam int SatCapInt = (LineLengthMax < 65535) ? LineLengthMax : 65535;
   localparam logic [15:0] SatCap = 16'(SatCapInt);

   // Token queue between front and back; depth must be a power of two.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW = $clog2(QueueDepth);

   // Input item functions.
   localparam logic [1:0] FuncData = 2'd0;
   localparam logic [1:0] FuncEol  = 2'd1;
   localparam logic [1:0] FuncEos  = 2'd2;

   // Token kinds.
   localparam logic [3:0] TkHeading = 4'd0;
   localparam logic [3:0] TkEmph    = 4'd1;
   localparam logic [3:0] TkStrike  = 4'd2;
   localparam logic [3:0] TkCode    = 4'd3;
   localparam logic [3:0] TkQuote   = 4'd4;
   localparam logic [3:0] TkNewline = 4'd5;
   localparam logic [3:0] TkText    = 4'd6;
   localparam logic [3:0] TkError   = 4'd7;
   localparam logic [3:0] TkDone    = 4'd8;

   // Error codes.
   localparam logic [1:0] ErrNone    = 2'd0;
   localparam logic [1:0] ErrHeading = 2'd1;
   localparam logic [1:0] ErrEmph    = 2'd2;
   localparam logic [1:0] ErrCode    = 2'd3;

   // Marker bytes.
   localparam logic [7:0] ChHash  = 8'h23;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChUnder = 8'h5F;
   localparam logic [7:0] ChTick  = 8'h60;
   localparam logic [7:0] ChTilde = 8'h7E;
   localparam logic [7:0] ChGt    = 8'h3E;
   localparam logic [7:0] ChNl    = 8'h0A;

   // Run limits.
   localparam logic [15:0] HeadingMax = 16'd6;
   localparam logic [15:0] EmphMax    = 16'd3;
   localparam logic [15:0] CodeShort  = 16'd1;
   localparam logic [15:0] CodeLong   = 16'd3;

   // One result item without its last flag.
   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  level;
      logic [15:0] start;
      logic [15:0] length;
      logic [1:0]  err;
   } token_type;

   // The results of one input item: one token, or two when second is set.
   typedef struct packed {
      logic      second;
      token_type tok0;
      token_type tok1;
   } bundle_type;

   // Queue status seen by the front handshake and the back.
   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage

FILE: hw/rtl/markup_run_tokenizer.sv
// Markup run tokenizer top level: front, token queue and back.
// The first result of an item passes through the bundle queue and then the output register.
// Throughput: one item per cycle while the queue has room; the output sends one result
// a cycle while rsp_ready holds, so an item that causes two results holds the output for
// both and the four-entry bundle queue absorbs that. Input stalls only while the queue is full.
// Synchronous reset clears run state, queue pointers and the output valid.
module markup_run_tokenizer import mrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_token_kind,
   output logic [2:0]  rsp_level,
   output logic [15:0] rsp_text_start,
   output logic [15:0] rsp_text_length,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

`include "markup_run_tokenizer_assert.svh"

   logic         take;
   logic         push;
   logic         pop;
   bundle_type   wr_bundle;
   bundle_type   head;
   q_status_type q_status;
   token_type    rsp_tok;

   // A beat is taken whenever the queue has room.
   assign req_ready = !q_status.full;
   assign take      = req_valid && req_ready;

   mrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .func      (req_func),
      .char_code (req_char_code),
      .push      (push),
      .bundle    (wr_bundle)
   );

   mrt_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_bundle),
      .pop     (pop),
      .rd_data (head),
      .status  (q_status)
   );

   mrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (head),
      .pop       (pop),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_tok   (rsp_tok),
      .rsp_last  (rsp_last)
   );

   assign rsp_token_kind  = rsp_tok.kind;
   assign rsp_level       = rsp_tok.level;
   assign rsp_text_start  = rsp_tok.start;
   assign rsp_text_length = rsp_tok.length;
   assign rsp_error_code  = rsp_tok.err;

   // Checks on the block's own logic.
   `MRT_ASSERT_IMPL(a_done_last, clock, reset, rsp_valid && rsp_token_kind == TkDone, rsp_last, "done token without last")
   `MRT_ASSERT_IMPL(a_error_code, clock, reset, rsp_valid && rsp_token_kind == TkError, rsp_error_code != ErrNone, "error token without a code")
   `MRT_ASSERT_IMPL(a_full_has_head, clock, reset, !req_ready, q_status.valid, "full queue reports no head")
   `MRT_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, q_status.valid, "pushed bundle lost")

endmodule

FILE: hw/rtl/mrt_front.sv
// Front of the markup run tokenizer: classifies bytes, tracks the pending run
// and builds the tokens of each accepted item. Depends on mrt_pkg.
module mrt_front import mrt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [1:0] func,
   input  logic [7:0] char_code,
   output logic       push,
   output bundle_type bundle
);

   typedef enum logic [2:0] {
      CLS_NONE, CLS_HASH, CLS_STAR, CLS_UNDER, CLS_TICK, CLS_TEXT, CLS_SINGLE
   } run_class_type;

   run_class_type run_class_ff, run_class_in;
   logic [15:0]   run_count_ff, run_count_in;
   logic [15:0]   run_begin_ff, run_begin_in;
   logic [15:0]   line_position_ff, line_position_in;
   logic          halted_ff, halted_in;

   logic          fl_valid;
   logic          fl_err;
   token_type     fl_tok;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v < SatCap) ? v + 16'd1 : SatCap;
   endfunction

   function automatic run_class_type classify(input logic [7:0] ch);
      case (ch)
         ChHash:  return CLS_HASH;
         ChStar:  return CLS_STAR;
         ChUnder: return CLS_UNDER;
         ChTick:  return CLS_TICK;
         ChTilde, ChGt, ChNl: return CLS_SINGLE;
         default: return CLS_TEXT;
      endcase
   endfunction

   function automatic token_type make_tok(input logic [3:0] kind, input logic [2:0] level,
                                          input logic [15:0] start,
                                          input logic [15:0] length,
                                          input logic [1:0] err);
      token_type t;
      t.kind   = kind;
      t.level  = level;
      t.start  = start;
      t.length = length;
      t.err    = err;
      return t;
   endfunction

   // Token the pending run would give if flushed now, with its limit check.
   always_comb begin
      fl_valid = 1'b1;
      fl_err   = 1'b0;
      fl_tok   = '0;
      case (run_class_ff)
         CLS_HASH: begin
            if (run_count_ff > HeadingMax) begin
               fl_err = 1'b1;
               fl_tok = make_tok(TkError, 3'd0, 16'd0, 16'd0, ErrHeading);
            end else begin
               fl_tok = make_tok(TkHeading, run_count_ff[2:0], 16'd0, 16'd0, ErrNone);
            end
         end
         CLS_STAR, CLS_UNDER: begin
            if (run_count_ff > EmphMax) begin
               fl_err = 1'b1;
               fl_tok = make_tok(TkError, 3'd0, 16'd0, 16'd0, ErrEmph);
            end else begin
               fl_tok = make_tok(TkEmph, run_count_ff[2:0], 16'd0, 16'd0, ErrNone);
            end
         end
         CLS_TICK: begin
            if (run_count_ff != CodeShort && run_count_ff != CodeLong) begin
               fl_err = 1'b1;
               fl_tok = make_tok(TkError, 3'd0, 16'd0, 16'd0, ErrCode);
            end else begin
               fl_tok = make_tok(TkCode, run_count_ff[2:0], 16'd0, 16'd0, ErrNone);
            end
         end
         CLS_TEXT: begin
            fl_tok = make_tok(TkText, 3'd0, run_begin_ff, run_count_ff, ErrNone);
         end
         default: begin
            fl_valid = 1'b0;
         end
      endcase
   end

   // Per-item token generation and run state update.
   always_comb begin
      run_class_type c;
      logic          brk;
      token_type     single_tok;
      token_type     done_tok;
      token_type     nl_tok;

      c          = classify(char_code);
      brk        = (run_class_ff != CLS_NONE) && (run_class_ff != c);
      done_tok   = make_tok(TkDone, 3'd0, 16'd0, 16'd0, ErrNone);
      nl_tok     = make_tok(TkNewline, 3'd0, 16'd0, 16'd0, ErrNone);
      if (char_code == ChTilde) begin
         single_tok = make_tok(TkStrike, 3'd0, 16'd0, 16'd0, ErrNone);
      end else if (char_code == ChGt) begin
         single_tok = make_tok(TkQuote, 3'd0, 16'd0, 16'd0, ErrNone);
      end else begin
         single_tok = nl_tok;
      end

      run_class_in     = run_class_ff;
      run_count_in     = run_count_ff;
      run_begin_in     = run_begin_ff;
      line_position_in = line_position_ff;
      halted_in        = halted_ff;
      push             = 1'b0;
      bundle           = '0;

      if (take) begin
         case (func)
            // End of source: flush unless halted, then done, then back to reset.
            FuncEos: begin
               push = 1'b1;
               if (!halted_ff && fl_valid) begin
                  bundle.tok0   = fl_tok;
                  bundle.tok1   = done_tok;
                  bundle.second = 1'b1;
               end else begin
                  bundle.tok0 = done_tok;
               end
               run_class_in     = CLS_NONE;
               run_count_in     = 16'd0;
               run_begin_in     = 16'd0;
               line_position_in = 16'd0;
               halted_in        = 1'b0;
            end
            // End of line: flush, then a newline token unless the flush failed.
            FuncEol: begin
               if (!halted_ff) begin
                  push         = 1'b1;
                  run_class_in = CLS_NONE;
                  run_count_in = 16'd0;
                  if (fl_valid && fl_err) begin
                     bundle.tok0 = fl_tok;
                     halted_in   = 1'b1;
                  end else if (fl_valid) begin
                     bundle.tok0      = fl_tok;
                     bundle.tok1      = nl_tok;
                     bundle.second    = 1'b1;
                     line_position_in = 16'd0;
                  end else begin
                     bundle.tok0      = nl_tok;
                     line_position_in = 16'd0;
                  end
               end
            end
            // Data byte: extend the run, or flush it and start another.
            FuncData: begin
               if (!halted_ff) begin
                  if (brk && fl_err) begin
                     push         = 1'b1;
                     bundle.tok0  = fl_tok;
                     halted_in    = 1'b1;
                     run_class_in = CLS_NONE;
                     run_count_in = 16'd0;
                  end else begin
                     if (c == CLS_SINGLE) begin
                        push         = 1'b1;
                        run_class_in = CLS_NONE;
                        run_count_in = 16'd0;
                        if (brk) begin
                           bundle.tok0   = fl_tok;
                           bundle.tok1   = single_tok;
                           bundle.second = 1'b1;
                        end else begin
                           bundle.tok0 = single_tok;
                        end
                     end else if (run_class_ff == c) begin
                        run_count_in = sat_inc(run_count_ff);
                     end else begin
                        run_class_in = c;
                        run_count_in = 16'd1;
                        run_begin_in = line_position_ff;
                        if (brk) begin
                           push        = 1'b1;
                           bundle.tok0 = fl_tok;
                        end
                     end
                     line_position_in = sat_inc(line_position_ff);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Run state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff     <= CLS_NONE;
         run_count_ff     <= 16'd0;
         run_begin_ff     <= 16'd0;
         line_position_ff <= 16'd0;
         halted_ff        <= 1'b0;
      end else begin
         run_class_ff     <= run_class_in;
         run_count_ff     <= run_count_in;
         run_begin_ff     <= run_begin_in;
         line_position_ff <= line_position_in;
         halted_ff        <= halted_in;
      end
   end

endmodule

FILE: hw/rtl/mrt_queue.sv
// Short queue of token bundles between the front and the back.
// Depends on mrt_pkg for the bundle type and the depth.
module mrt_queue import mrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bundle_type   wr_data,
   input  logic         pop,
   output bundle_type   rd_data,
   output q_status_type status
);

   bundle_type             entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     count_ff, count_in;

   // Pointer and fill count update; the depth is a power of two so pointers wrap.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QueuePtrW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QueuePtrW + 1)'(1);
      end
   end

   assign rd_data      = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == (QueuePtrW + 1)'(QueueDepth));

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/mrt_back.sv
// Back of the markup run tokenizer: takes bundles from the queue and sends
// their tokens one beat at a time through an output register. Depends on mrt_pkg.
module mrt_back import mrt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  bundle_type   head,
   output logic         pop,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output token_type    rsp_tok,
   output logic         rsp_last
);

   logic      rsp_valid_ff, rsp_valid_in;
   logic      sel_ff, sel_in;
   token_type rsp_tok_ff, rsp_tok_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      load;
   logic      is_last;

   // Load the output register whenever the queue has a bundle and the register is empty or its beat is taken.
   always_comb begin
      load         = q_status.valid && (!rsp_valid_ff || rsp_ready);
      is_last      = !head.second || sel_ff;
      pop          = load && is_last;
      rsp_valid_in = rsp_valid_ff;
      sel_in       = sel_ff;
      rsp_tok_in   = rsp_tok_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_tok_in   = sel_ff ? head.tok1 : head.tok0;
         rsp_last_in  = is_last;
         sel_in       = !is_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
      rsp_tok_ff  <= rsp_tok_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tok   = rsp_tok_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

FILE: tb/markup_run_tokenizer_tb.sv
// Self-checking testbench for the markup run tokenizer.
// Depends on mrt_pkg and markup_run_tokenizer; it drives markup bytes and checks every token.
module markup_run_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mrt_pkg::*;

   localparam int CycleLimit  = 1_000_000;
   localparam int TotalItems  = 1450;
   localparam int DrainCycles = 20;
   localparam int IdlePct     = 12;
   localparam int DirCount    = 25;
   localparam int ReportMax   = 10;
   localparam logic [1:0] FuncUnused = 2'd3;

   // Run classes of the tokenizer model.
   typedef enum logic [2:0] {
      RunNone, RunHash, RunStar, RunUnder, RunTick, RunText, RunSingle
   } run_kind_type;

   // One expected output beat.
   typedef struct packed {
      token_type tok;
      logic      last;
   } beat_type;

   // One stimulus row. When typed is set, the row causes a single result
   // of the given kind and error code with all other fields zero.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] ch;
      logic       typed;
      logic [3:0] kind;
      logic [1:0] err;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = FuncData;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [2:0]  rsp_level;
   logic [15:0] rsp_text_start;
   logic [15:0] rsp_text_length;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;

   // Tokenizer model state.
   run_kind_type cur_run = RunNone;
   logic [15:0]  cur_len = '0;
   logic [15:0]  cur_start = '0;
   logic [15:0]  col = '0;
   logic         stopped = 1'b0;

   token_type   item_toks[$];
   beat_type    expected_beats[$];

   int mismatches = 0;
   int beats_checked = 0;
   int items_sent = 0;
   int documents = 0;
   int halts = 0;
   int cycle_count = 0;
   logic calm = 1'b0;

   // Directed rows: every marker class, the byte extremes, the unused
   // function, a code run of bad length, a halted line, and an emphasis
   // run that breaks its limit right at end of source.
   dir_row_type dir_rows [DirCount] = '{
      '{FuncEos,    8'h00,   1'b1, TkDone,  ErrNone},
      '{FuncData,   8'h00,   1'b0, TkText,  ErrNone},
      '{FuncData,   8'hFF,   1'b0, TkText,  ErrNone},
      '{FuncData,   ChHash,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChHash,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChStar,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChUnder, 1'b0, TkText,  ErrNone},
      '{FuncData,   ChTick,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChTilde, 1'b0, TkText,  ErrNone},
      '{FuncData,   ChGt,    1'b0, TkText,  ErrNone},
      '{FuncData,   ChNl,    1'b0, TkText,  ErrNone},
      '{FuncUnused, 8'hFF,   1'b0, TkText,  ErrNone},
      '{FuncData,   8'h78,   1'b0, TkText,  ErrNone},
      '{FuncEol,    8'h00,   1'b0, TkText,  ErrNone},
      '{FuncData,   ChTick,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChTick,  1'b0, TkText,  ErrNone},
      '{FuncData,   8'h79,   1'b1, TkError, ErrCode},
      '{FuncData,   8'h7A,   1'b0, TkText,  ErrNone},
      '{FuncEol,    8'h00,   1'b0, TkText,  ErrNone},
      '{FuncEos,    8'h00,   1'b1, TkDone,  ErrNone},
      '{FuncData,   ChStar,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChStar,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChStar,  1'b0, TkText,  ErrNone},
      '{FuncData,   ChStar,  1'b0, TkText,  ErrNone},
      '{FuncEos,    8'h00,   1'b0, TkText,  ErrNone}
   };

   markup_run_tokenizer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_char_code   (req_char_code),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_level       (rsp_level),
      .rsp_text_start  (rsp_text_start),
      .rsp_text_length (rsp_text_length),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic token_type make_tok(input logic [3:0] kind, input logic [2:0] level,
                                          input logic [15:0] start,
                                          input logic [15:0] length, input logic [1:0] err);
      token_type t;
      t.kind   = kind;
      t.level  = level;
      t.start  = start;
      t.length = length;
      t.err    = err;
      return t;
   endfunction

   function automatic logic [15:0] bump_sat(input logic [15:0] v);
      return (v < SatCap) ? v + 16'd1 : SatCap;
   endfunction

   function automatic run_kind_type byte_class(input logic [7:0] c);
      case (c)
         ChHash:            return RunHash;
         ChStar:            return RunStar;
         ChUnder:           return RunUnder;
         ChTick:            return RunTick;
         ChTilde, ChGt, ChNl: return RunSingle;
         default:           return RunText;
      endcase
   endfunction

   function automatic dir_row_type plain(input logic [1:0] f, input logic [7:0] c);
      dir_row_type r;
      r.func  = f;
      r.ch    = c;
      r.typed = 1'b0;
      r.kind  = TkText;
      r.err   = ErrNone;
      return r;
   endfunction

   // Append one token to the results of the current item.
   function automatic void add_tok(input token_type t);
      item_toks.insert(item_toks.size(), t);
   endfunction

   // A broken limit replaces the run's token and halts the document.
   function automatic void raise_error(input logic [1:0] code);
      add_tok(make_tok(TkError, 3'd0, 16'd0, 16'd0, code));
      stopped = 1'b1;
      halts++;
   endfunction

   // Emit the token of the pending run, if any, and clear the run.
   function automatic void close_run();
      run_kind_type kind;
      logic [15:0]  n;
      kind    = cur_run;
      n       = cur_len;
      cur_run = RunNone;
      cur_len = '0;
      case (kind)
         RunHash: begin
            if (n > HeadingMax) raise_error(ErrHeading);
            else add_tok(make_tok(TkHeading, n[2:0], 16'd0, 16'd0, ErrNone));
         end
         RunStar, RunUnder: begin
            if (n > EmphMax) raise_error(ErrEmph);
            else add_tok(make_tok(TkEmph, n[2:0], 16'd0, 16'd0, ErrNone));
         end
         RunTick: begin
            if (n != CodeShort && n != CodeLong) raise_error(ErrCode);
            else add_tok(make_tok(TkCode, n[2:0], 16'd0, 16'd0, ErrNone));
         end
         RunText: begin
            add_tok(make_tok(TkText, 3'd0, cur_start, n, ErrNone));
         end
         default: ;
      endcase
   endfunction

   // Work out the tokens that one accepted input beat causes.
   function automatic void tokenize_item(input logic [1:0] f, input logic [7:0] c);
      run_kind_type k;
      logic [3:0]   kind;
      item_toks.delete();
      if (f == FuncEos) begin
         if (!stopped) close_run();
         add_tok(make_tok(TkDone, 3'd0, 16'd0, 16'd0, ErrNone));
         cur_run   = RunNone;
         cur_len   = '0;
         cur_start = '0;
         col       = '0;
         stopped   = 1'b0;
      end else if (!stopped && f != FuncUnused) begin
         if (f == FuncEol) begin
            close_run();
            if (!stopped) begin
               add_tok(make_tok(TkNewline, 3'd0, 16'd0, 16'd0, ErrNone));
               col = '0;
            end
         end else begin
            k = byte_class(c);
            if (cur_run != RunNone && cur_run != k) close_run();
            if (!stopped) begin
               if (k == RunSingle) begin
                  kind = (c == ChTilde) ? TkStrike : ((c == ChGt) ? TkQuote : TkNewline);
                  add_tok(make_tok(kind, 3'd0, 16'd0, 16'd0, ErrNone));
               end else if (cur_run == k) begin
                  cur_len = bump_sat(cur_len);
               end else begin
                  cur_run   = k;
                  cur_len   = 16'd1;
                  cur_start = col;
               end
               col = bump_sat(col);
            end
         end
      end
   endfunction

   // Drive one input beat, starting and ending at a falling edge.
   task automatic send_item(input dir_row_type row);
      beat_type b;
      while (!calm && $urandom_range(0, 99) < IdlePct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= row.func;
      req_char_code <= row.ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      tokenize_item(row.func, row.ch);
      if (row.typed) begin
         b.tok  = make_tok(row.kind, 3'd0, 16'd0, 16'd0, row.err);
         b.last = 1'b1;
         expected_beats.insert(expected_beats.size(), b);
      end else begin
         foreach (item_toks[i]) begin
            b.tok  = item_toks[i];
            b.last = (i == item_toks.size() - 1);
            expected_beats.insert(expected_beats.size(), b);
         end
      end
      @(negedge clock);
   endtask

   // One random segment of a line: a text run, a marker run (now and then
   // over its limit), or a single-byte token, with occasional noise.
   task automatic send_segment();
      int         sel;
      int         pick;
      int         len;
      logic       over;
      logic [7:0] c;
      sel  = $urandom_range(0, 99);
      over = ($urandom_range(0, 99) < 6);
      if (sel < 40) begin
         len = $urandom_range(1, 8);
         repeat (len) send_item(plain(FuncData, 8'($urandom_range(0, 255))));
      end else if (sel < 80) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0: begin
               c   = ChHash;
               len = over ? $urandom_range(7, 9) : $urandom_range(1, 6);
            end
            1, 2: begin
               c   = (pick == 1) ? ChStar : ChUnder;
               len = over ? $urandom_range(4, 5) : $urandom_range(1, 3);
            end
            default: begin
               c = ChTick;
               if (over) len = $urandom_range(0, 1) ? 2 : $urandom_range(4, 5);
               else len = $urandom_range(0, 1) ? 1 : 3;
            end
         endcase
         repeat (len) send_item(plain(FuncData, c));
      end else begin
         pick = $urandom_range(0, 2);
         c    = (pick == 0) ? ChTilde : ((pick == 1) ? ChGt : ChNl);
         send_item(plain(FuncData, c));
      end
      if ($urandom_range(0, 99) < 4) begin
         send_item(plain(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
      end
   endtask

   // A document of a few lines, closed by end of source.
   task automatic send_document();
      int nlines;
      int nseg;
      documents++;
      nlines = $urandom_range(1, 4);
      for (int l = 0; l < nlines; l++) begin
         nseg = $urandom_range(0, 6);
         repeat (nseg) send_segment();
         if (l < nlines - 1) send_item(plain(FuncEol, 8'($urandom_range(0, 255))));
      end
      send_item(plain(FuncEos, 8'($urandom_range(0, 255))));
   endtask

   // Result side stalls at random, except in the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
   end

   // Compare each accepted result beat with the oldest expected token.
   always @(posedge clock) begin : check_blk
      beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportMax) begin
               $display("unexpected beat: kind %0d level %0d start %0d len %0d err %0d last %0d",
                        rsp_token_kind, rsp_level, rsp_text_start, rsp_text_length,
                        rsp_error_code, rsp_last);
            end
         end else begin
            want = expected_beats.pop_front();
            beats_checked++;
            if (rsp_token_kind !== want.tok.kind || rsp_level !== want.tok.level ||
                rsp_text_start !== want.tok.start || rsp_text_length !== want.tok.length ||
                rsp_error_code !== want.tok.err || rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= ReportMax) begin
                  $display("mismatch at beat %0d:", beats_checked);
                  $display("  expected kind %0d level %0d start %0d len %0d err %0d last %0d",
                           want.tok.kind, want.tok.level, want.tok.start,
                           want.tok.length, want.tok.err, want.last);
                  $display("  got      kind %0d level %0d start %0d len %0d err %0d last %0d",
                           rsp_token_kind, rsp_level, rsp_text_start, rsp_text_length,
                           rsp_error_code, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CycleLimit) @(posedge clock);
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("tb: failure");
      $finish;
   end

   // Reset, directed rows, random documents, drain.
   initial begin : stim_blk
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirCount; i++) send_item(dir_rows[i]);

      while (items_sent < TotalItems) begin
         calm = (items_sent >= 600 && items_sent < 900);
         send_document();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("summary: %0d input beats, the directed rows and then %0d random documents",
               items_sent, documents);
      $display("summary: %0d tokens checked, %0d limit halts, %0d failures",
               beats_checked, halts, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
